// ===== rtl/core/fir_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_pkg: shared types for the circular delay line FIR filter
// Input and result beat layouts.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int INDEX_W  = 6;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
  } fir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic [2*SAMPLE_W-1:0]      stereo_word;
    logic                       saturated;
  } fir_out_t;

endpackage

// ===== rtl/core/fir_filter_circular_delay_line_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_circular_delay_line_top: direct-form FIR over a circular buffer
// Each tap runs a memory read, a multiplier start, 16 coefficient bits and
// one idle check. No new beat is taken until the result is loaded into the
// output register; coefficient loads are taken in idle and stay in idle.
// Reset clears the pointers, then a clearing pass over all TAPS entries
// zeros both memories; no input is taken during the pass.
// ----------------------------------------------------------------------------
module fir_filter_circular_delay_line_top
  import fir_pkg::*;
#(
  parameter int TAPS           = 64,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  fir_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output fir_out_t out_data
);

  localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int ACC_W = 2 * SAMPLE_W + PTR_W + 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_MUL   = 6'b001000,
    S_WAIT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  logic signed [SAMPLE_W-1:0] coef_mem  [TAPS];
  logic signed [SAMPLE_W-1:0] delay_mem [TAPS];
  logic signed [SAMPLE_W-1:0] coef_rd, smp_rd;
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] tap_cnt;
  logic             accept, mac_start, mac_clear, mac_busy;
  logic             out_load;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_adj, y;
  logic                    sat;
  logic signed [SAMPLE_W-1:0] y16;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // hold the finished sum in done until the output register is free
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(TAPS-1)) ? '0 : p + 1'b1;
  endfunction

  // memories
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      coef_mem[tap_cnt[PTR_W-1:0]]  <= '0;
      delay_mem[tap_cnt[PTR_W-1:0]] <= '0;
    end else if (accept && in_data.mode == MODE_LOAD) begin
      if (32'(in_data.coef_index) < TAPS)
        coef_mem[in_data.coef_index[PTR_W-1:0]] <= in_data.coef_value;
    end else if (accept) begin
      delay_mem[wptr] <= in_data.sample_in;
    end
    coef_rd <= coef_mem[tap_cnt[PTR_W-1:0]];
    smp_rd  <= delay_mem[rptr];
  end

  assign mac_start = (state == S_MUL);
  assign mac_clear = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      wptr      <= '0;
      rptr      <= '0;
      tap_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (tap_cnt == CNT_W'(TAPS-1)) begin
            tap_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            tap_cnt <= tap_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept && in_data.mode == MODE_FILTER) begin
            wptr    <= ptr_inc(wptr);
            rptr    <= ptr_inc(wptr);
            tap_cnt <= '0;
            state   <= S_READ;
          end
        end
        S_READ: state <= S_MUL;   // wait on registered reads
        S_MUL:  state <= S_WAIT;
        S_WAIT: begin
          if (!mac_busy) begin
            if (tap_cnt == CNT_W'(TAPS-1)) begin
              state <= S_DONE;
            end else begin
              tap_cnt <= tap_cnt + 1'b1;
              rptr    <= ptr_inc(rptr);
              state   <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fir_serial_mac #(.ACC_W(ACC_W)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (mac_clear),
    .start  (mac_start),
    .sample (smp_rd),
    .coef   (coef_rd),
    .busy   (mac_busy),
    .acc    (acc)
  );

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    acc_adj = acc;
    if (acc[ACC_W-1]) acc_adj = acc + ACC_W'((64'd1 << COEF_FRAC_BITS) - 1);
    y   = acc_adj >>> COEF_FRAC_BITS;
    sat = 1'b0;
    y16 = y[SAMPLE_W-1:0];
    if (y > ACC_W'(32767)) begin
      y16 = 16'sh7fff;
      sat = 1'b1;
    end else if (y < -ACC_W'(32768)) begin
      y16 = -16'sh8000;
      sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.filtered_sample <= y16;
      out_data.stereo_word     <= {y16, y16};
      out_data.saturated       <= sat;
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept |-> state == S_IDLE)
    else $error("beat taken outside idle");
  assert property (@(posedge clk) disable iff (rst) out_load |=> out_valid)
    else $error("result not raised");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
    state == S_WAIT && mac_busy |=> state == S_WAIT)
    else $error("left wait with product in flight");

endmodule

// ===== rtl/core/fir_serial_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_serial_mac: bit-serial multiply-accumulate
// Multiplies a signed sample by a signed coefficient one coefficient bit per
// cycle and adds the product into a wide accumulator.
// ----------------------------------------------------------------------------
module fir_serial_mac
  import fir_pkg::*;
#(
  parameter int ACC_W = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic signed [SAMPLE_W-1:0] coef,
  output logic                       busy,
  output logic signed [ACC_W-1:0]    acc
);

  localparam int CNT_W = $clog2(SAMPLE_W);

  logic [SAMPLE_W-1:0]        coef_sr;
  logic signed [ACC_W-1:0]    addend;
  logic [CNT_W-1:0]           bit_cnt;

  // addend is sample shifted by the current bit position; top bit has
  // negative weight in two's complement
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_cnt <= '0;
      acc     <= '0;
    end else begin
      if (clear) acc <= '0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
        coef_sr <= coef;
        addend  <= ACC_W'(sample);
      end else if (busy) begin
        if (coef_sr[0]) begin
          if (bit_cnt == CNT_W'(SAMPLE_W-1)) acc <= acc - addend;
          else acc <= acc + addend;
        end
        coef_sr <= coef_sr >> 1;
        addend  <= addend <<< 1;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == CNT_W'(SAMPLE_W-1)) busy <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("mac did not start");
  assert property (@(posedge clk) disable iff (rst)
    busy && bit_cnt == CNT_W'(SAMPLE_W-1) |=> !busy)
    else $error("mac ran past last bit");
  assert property (@(posedge clk) disable iff (rst) busy |-> !clear)
    else $error("accumulator cleared mid product");

endmodule
